// File: src/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Item formats, command codes and sizing of the fully associative store.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int OCC_W   = 5;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef struct packed {
		logic                    command;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic [OCC_W-1:0]        occupancy;
	} out_item_t;

endpackage

// File: src/lkvc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_core: entry store with parallel lookup and recency update
// Holds keys, values, recency ranks and valid flags; works out the result of
// one item combinationally and commits the new state on the same edge.
// ----------------------------------------------------------------------------
module lkvc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          process,
	input  lkvc_pkg::in_item_t            item,
	input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
	output lkvc_pkg::out_item_t           result
);

	logic [lkvc_pkg::KEY_W-1:0]  key_q   [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0]  value_q [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::RANK_W-1:0] rank_q  [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::ENTRIES-1:0] valid_q;
	logic [lkvc_pkg::CNT_W-1:0]   count_q;

	logic [lkvc_pkg::ENTRIES-1:0] match;
	logic [lkvc_pkg::ENTRIES-1:0] evict;
	logic [lkvc_pkg::ENTRIES-1:0] kept;
	logic [lkvc_pkg::ENTRIES-1:0] free_slot;
	logic [lkvc_pkg::ENTRIES-1:0] valid_n;
	logic [lkvc_pkg::ENTRIES-1:0] wr_key;
	logic [lkvc_pkg::ENTRIES-1:0] wr_val;
	logic [lkvc_pkg::RANK_W-1:0]  rank_n [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::RANK_W-1:0]  hit_rank;
	logic [lkvc_pkg::RANK_W-1:0]  oldest_rank;
	logic [lkvc_pkg::VAL_W-1:0]   hit_value;
	logic [lkvc_pkg::CNT_W-1:0]   eff_cap;
	logic [lkvc_pkg::CNT_W-1:0]   count_n;
	logic                         hit;
	logic                         is_put;
	logic                         need_evict;
	logic                         insert;

	// Keys among valid entries are distinct, so at most one entry matches and
	// its rank and value can be collected by OR.
	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == item.key);
			if (match[i]) begin
				hit_rank  = hit_rank | rank_q[i];
				hit_value = hit_value | value_q[i];
			end
		end
	end

	assign hit    = |match;
	assign is_put = (item.command == lkvc_pkg::CMD_PUT);

	always_comb begin
		if (capacity == '0) begin
			eff_cap = lkvc_pkg::CNT_W'(1);
		end else if (32'(capacity) > lkvc_pkg::ENTRIES) begin
			eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
		end else begin
			eff_cap = lkvc_pkg::CNT_W'(capacity);
		end
	end

	// Valid ranks are always 0 .. count-1, so the least recent entry is the one
	// ranked count-1.
	assign need_evict  = is_put && !hit && (count_q >= eff_cap);
	assign oldest_rank = lkvc_pkg::RANK_W'(count_q - lkvc_pkg::CNT_W'(1));

	always_comb begin
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
			evict[i] = need_evict && valid_q[i] && (rank_q[i] == oldest_rank);
		end
	end

	assign kept      = valid_q & ~evict;
	assign free_slot = ~kept & (kept + lkvc_pkg::ENTRIES'(1));
	assign insert    = is_put && !hit && (|free_slot);
	assign valid_n   = insert ? (kept | free_slot) : kept;
	assign count_n   = lkvc_pkg::CNT_W'(count_q - lkvc_pkg::CNT_W'(|evict)
		+ lkvc_pkg::CNT_W'(insert));

	always_comb begin
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
			rank_n[i] = rank_q[i];
			if (hit) begin
				if (match[i]) begin
					rank_n[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_n[i] = rank_q[i] + lkvc_pkg::RANK_W'(1);
				end
			end else if (insert) begin
				if (free_slot[i]) begin
					rank_n[i] = '0;
				end else if (kept[i]) begin
					rank_n[i] = rank_q[i] + lkvc_pkg::RANK_W'(1);
				end
			end
			wr_key[i] = insert && free_slot[i];
			wr_val[i] = (is_put && match[i]) || (insert && free_slot[i]);
		end
	end

	always_comb begin
		result.hit        = hit;
		result.read_value = (!is_put && hit) ? hit_value : lkvc_pkg::MISS_VALUE;
		result.occupancy  = lkvc_pkg::OCC_W'(count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (process) begin
			valid_q <= valid_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
				rank_q[i] <= rank_n[i];
				if (wr_key[i]) begin
					key_q[i] <= item.key;
				end
				if (wr_val[i]) begin
					value_q[i] <= item.value;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("entry count differs from number of valid flags");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= lkvc_pkg::ENTRIES)
		else $error("entry count exceeds the store size");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key found in more than one entry");

	a_single_victim: assert property (@(posedge clk) disable iff (!arst_n)
		need_evict |-> $onehot(evict))
		else $error("eviction does not select exactly one entry");

	a_put_leaves_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(process && is_put) |=> (valid_q != '0))
		else $error("store empty after a put");
`endif

endmodule

// File: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Input register, combinational lookup and update, registered result.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready/in_data: a get looks up in_data.key,
// a put writes in_data.value under that key. Every request beat yields one
// result beat on out_valid/out_ready/out_data carrying hit, the read value
// (all ones on a get miss and on every put) and the occupancy afterward.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data,
// which always accepts; write it only while the cache is empty and idle.
// A request beat first lands in the input register; then the lookup, the
// recency update and the state write happen together and land in the result
// register. One request per cycle is sustained while the receiver keeps
// out_ready high, made possible by the parallel compare of all entries. When
// the receiver stalls, the result register holds and the input register
// fills; in_ready drops only once both are occupied.
// Reset clears all valid flags and the entry count and sets capacity to 16;
// no clearing pass is needed and requests are taken right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lkvc_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lkvc_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);

	lkvc_pkg::in_item_t         item_s1;
	lkvc_pkg::out_item_t        result_s2;
	lkvc_pkg::out_item_t        result_c;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       advance;
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	lkvc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.process  (advance),
		.item     (item_s1),
		.capacity (capacity_q),
		.result   (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result_c;
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the LRU key/value cache
// Drives get and put requests under random idling and back-pressure. A local
// copy of the key, value, rank and valid arrays predicts every reply. Replies
// are compared field by field in order. The capacity register is swept across
// its range, including zero, values above the entry count, and lowering
// below the current occupancy.
// ----------------------------------------------------------------------------
module tb;

	import lkvc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int          POOL_SIZE   = 20;

	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	// Predicted cache contents.
	logic [KEY_W-1:0]  slot_key   [ENTRIES];
	logic [VAL_W-1:0]  slot_value [ENTRIES];
	logic [RANK_W-1:0] slot_rank  [ENTRIES];
	logic              slot_valid [ENTRIES];
	logic [CNT_W-1:0]  fill_count;
	logic [CAP_W-1:0]  cap_setting;

	out_item_t        expected_replies [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               pool_span;
	int unsigned      mismatch_count = 0;
	int unsigned      cycle_count = 0;
	int               hold_request = 0;
	logic             src_idle_en = 1'b0;
	logic             sink_idle_en = 1'b0;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Every valid entry more recent than the slot ages by one.
	function automatic void make_recent(input int slot);
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_valid[i] && slot_rank[i] < slot_rank[slot])
				slot_rank[i]++;
		end
		slot_rank[slot] = '0;
	endfunction

	function automatic out_item_t lookup_and_update(input in_item_t req);
		out_item_t reply;
		int        i;
		int        slot;
		int        oldest;
		int        free_slot;
		int        limit;
		logic      found;
		found = 1'b0;
		slot  = 0;
		for (i = 0; i < ENTRIES; i++) begin
			if (!found && slot_valid[i] && slot_key[i] == req.key) begin
				found = 1'b1;
				slot  = i;
			end
		end
		reply.hit        = found;
		reply.read_value = MISS_VALUE;
		if (req.command == CMD_PUT && found) begin
			make_recent(slot);
			slot_value[slot] = req.value;
		end else if (req.command == CMD_PUT) begin
			limit = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
			if (fill_count >= limit) begin
				oldest = -1;
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
						oldest = i;
				end
				if (oldest >= 0) begin
					slot_valid[oldest] = 1'b0;
					fill_count--;
				end
			end
			free_slot = -1;
			for (i = 0; i < ENTRIES; i++) begin
				if (!slot_valid[i]) begin
					if (free_slot < 0)
						free_slot = i;
				end else begin
					slot_rank[i]++;
				end
			end
			if (free_slot >= 0) begin
				slot_key[free_slot]   = req.key;
				slot_value[free_slot] = req.value;
				slot_rank[free_slot]  = '0;
				slot_valid[free_slot] = 1'b1;
				fill_count++;
			end
		end else if (found) begin
			make_recent(slot);
			reply.read_value = slot_value[slot];
		end
		reply.occupancy = OCC_W'(fill_count);
		return reply;
	endfunction

	// Leaves in_valid high after the beat unless an idle burst follows, so that
	// back-to-back requests never lower and raise valid in one time step.
	task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] value);
		in_item_t req;
		req.command = cmd;
		req.key     = key;
		req.value   = value;
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_replies.push_back(lookup_and_update(req));
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		cap_setting = cap;
	endtask

	task automatic refresh_pool(input int span);
		int i;
		for (i = 0; i < POOL_SIZE; i++) begin
			if ($urandom_range(0, 2) == 0)
				key_pool[i] = $urandom;
		end
		pool_span = (span > POOL_SIZE) ? POOL_SIZE : span;
	endtask

	// Mostly keys from the pool so that hits, updates and evictions are common;
	// one in ten is a fresh random key.
	task automatic send_mixed(input int count);
		int               n;
		logic [KEY_W-1:0] key;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, pool_span - 1)];
			send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, $urandom);
		end
	endtask

	// Capacity zero behaves as one; then an update and read at capacity one.
	task automatic test_small_capacity();
		set_capacity(CAP_W'(0));
		send_request(CMD_GET, KEY_MIN, 32'h0);
		send_request(CMD_PUT, KEY_MIN, VAL_MAX);
		send_request(CMD_PUT, KEY_MAX, VAL_MIN);
		send_request(CMD_GET, KEY_MIN, 32'h0);
		set_capacity(CAP_W'(1));
		send_request(CMD_PUT, KEY_MAX, 32'h0);
		send_request(CMD_GET, KEY_MAX, VAL_MAX);
	endtask

	// Capacity above the entry count saturates; fill and evict the oldest.
	task automatic test_fill_and_evict();
		int i;
		set_capacity(CAP_W'(31));
		send_request(CMD_PUT, 32'h0, VAL_MAX);
		send_request(CMD_PUT, 32'hFFFF_FFFF, VAL_MIN);
		send_request(CMD_GET, 32'h0, 32'h0);
		send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
		for (i = 1; i <= 14; i++)
			send_request(CMD_PUT, i * 32'h1111_1111, $urandom);
		send_request(CMD_GET, KEY_MAX, 32'h0);
	endtask

	// Capacity below occupancy: inserts evict one each, occupancy holds.
	task automatic test_capacity_below_fill();
		set_capacity(CAP_W'(3));
		send_request(CMD_PUT, 32'h0F0F_0F0F, 32'h1234_5678);
		send_request(CMD_GET, 32'h0F0F_0F0F, 32'h0);
	endtask

	task automatic test_random_phases();
		int unsigned caps [11] = '{16, 4, 9, 0, 31, 2, 17, 13, 1, 16, 7};
		int          p;
		int          eff;
		for (p = 0; p < 11; p++) begin
			set_capacity(CAP_W'(caps[p]));
			eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
			refresh_pool(eff + 4);
			src_idle_en  = (p % 3 != 0);
			sink_idle_en = (p % 2 == 0);
			send_mixed(80);
		end
	endtask

	task automatic test_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		refresh_pool(POOL_SIZE);
		hold_request = 80;
		send_mixed(30);
		drain_replies();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		send_mixed(30);
	endtask

	task automatic test_streaming();
		set_capacity(CAP_W'(16));
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		refresh_pool(POOL_SIZE);
		send_mixed(160);
	endtask

	// Reply sink: random stall bursts, or one long hold-off when requested.
	initial begin : reply_sink
		int stall;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				stall        = hold_request;
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (stall - 1)
					@(posedge clk);
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 16))
					@(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : reply_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply beat, expected none, actual %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (out_data.hit !== want.hit) begin
					$display("%0t: hit mismatch, expected %0b, actual %0b",
						$time, want.hit, out_data.hit);
					mismatch_count++;
				end
				if (out_data.read_value !== want.read_value) begin
					$display("%0t: read_value mismatch, expected %h, actual %h",
						$time, want.read_value, out_data.read_value);
					mismatch_count++;
				end
				if (out_data.occupancy !== want.occupancy) begin
					$display("%0t: occupancy mismatch, expected %0d, actual %0d",
						$time, want.occupancy, out_data.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int i;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		for (i = 0; i < ENTRIES; i++) begin
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_rank[i]  = '0;
			slot_valid[i] = 1'b0;
		end
		fill_count  = '0;
		cap_setting = CAP_RESET;
		for (i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		pool_span = POOL_SIZE;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_capacity();
		test_fill_and_evict();
		test_capacity_below_fill();
		test_random_phases();
		test_backpressure();
		test_streaming();

		drain_replies();
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
src/lkvc_pkg.sv
src/lkvc_core.sv
src/lru_key_value_cache.sv
verif/tb.sv
